// ----- src/bsis_pkg.sv -----
// bsis_pkg: shared types and constants of the bilinear sub-pixel image shift block
// controller state encoding, datapath command and status structs
// no dependencies
package bsis_pkg;

   localparam int PIX_W      = 8;
   localparam int SIZE_W     = 9;
   localparam int SHIFT_W    = 16;
   localparam int FRAC_W     = 13;
   localparam int ONE_Q13    = 1 << FRAC_W;
   localparam int SHIFT_LIM  = 16384;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_X      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Y      = 2'd3;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_PX   = 11'b000_0000_0010,
      S_PY   = 11'b000_0000_0100,
      S_SE   = 11'b000_0000_1000,
      S_SW   = 11'b000_0001_0000,
      S_NE   = 11'b000_0010_0000,
      S_FIN  = 11'b000_0100_0000,
      S_CHK  = 11'b000_1000_0000,
      S_RD   = 11'b001_0000_0000,
      S_ACC  = 11'b010_0000_0000,
      S_OUT  = 11'b100_0000_0000
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_PX,
      OP_PY,
      OP_SE,
      OP_SW,
      OP_NE,
      OP_FIN,
      OP_CHK,
      OP_READ,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] rd_nb;
      logic       acc_en;
      logic [1:0] acc_nb;
   } cmd_type;

   typedef struct packed {
      logic first_pix;
      logic out_free;
   } sts_type;

endpackage

// ----- src/bsis_ram.sv -----
// bsis_ram: generic one-write one-read memory with registered read data
// no dependencies
module bsis_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bsis_ctrl.sv -----
// bsis_ctrl: per-pixel sequencer of the image shift block
// depends on bsis_pkg for state, command and status types
module bsis_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bsis_pkg::sts_type sts,
   output bsis_pkg::cmd_type cmd
);
   import bsis_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] nb_ff, nb_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nb_ff    <= '0;
      end else begin
         state_ff <= state_in;
         nb_ff    <= nb_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      nb_in      = nb_ff;
      req_tready = 1'b0;
      cmd        = '{op: OP_NONE, rd_nb: nb_ff, acc_en: 1'b0, acc_nb: nb_ff - 2'd1};
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_CAPTURE;
               state_in = sts.first_pix ? S_PX : S_CHK;
            end
         end
         S_PX: begin
            cmd.op   = OP_PX;
            state_in = S_PY;
         end
         S_PY: begin
            cmd.op   = OP_PY;
            state_in = S_SE;
         end
         S_SE: begin
            cmd.op   = OP_SE;
            state_in = S_SW;
         end
         S_SW: begin
            cmd.op   = OP_SW;
            state_in = S_NE;
         end
         S_NE: begin
            cmd.op   = OP_NE;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = OP_FIN;
            state_in = S_CHK;
         end
         S_CHK: begin
            cmd.op   = OP_CHK;
            nb_in    = '0;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.op     = OP_READ;
            cmd.acc_en = (nb_ff != 2'd0);
            nb_in      = nb_ff + 2'd1;
            if (nb_ff == 2'd3) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- src/bsis_dp.sv -----
// bsis_dp: datapath of the image shift block: registers, frame latch math,
// neighbor addressing, blend accumulators and output register; uses bsis_pkg
module bsis_dp #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int WEIGHT_SHIFT = 7,
   parameter int AW           = 17
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bsis_pkg::cmd_type                  cmd,
   output bsis_pkg::sts_type                  sts,
   input  logic                               csr_valid,
   input  logic [bsis_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bsis_pkg::SHIFT_W-1:0]       csr_data,
   input  logic [3*bsis_pkg::PIX_W-1:0]       req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [3*bsis_pkg::PIX_W-1:0]       rsp_tdata,
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   output logic                               wr_en,
   output logic [AW-1:0]                      wr_addr,
   output logic [3*bsis_pkg::PIX_W-1:0]       wr_data,
   output logic                               rd_en,
   output logic [AW-1:0]                      rd_addr,
   input  logic [3*bsis_pkg::PIX_W-1:0]       rd_data
);
   import bsis_pkg::*;

   localparam int WTW       = WEIGHT_SHIFT + 1;
   localparam int ACW       = PIX_W + WTW + 2;
   localparam int PXW       = 26;
   localparam int WHW       = PXW - FRAC_W;
   localparam int CW        = 15;
   localparam int BANK_SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int WT_LSB    = 2 * FRAC_W - WEIGHT_SHIFT;

   // configuration
   logic [SIZE_W-1:0]         fw_ff, fh_ff;
   logic signed [SHIFT_W-1:0] sx_ff, sy_ff;
   // frame and pixel state
   logic [SIZE_W-1:0]         i_ff, j_ff;
   logic                      bank_ff, have_ff;
   logic [3*PIX_W-1:0]        pix_ff;
   logic signed [PXW-1:0]     px_ff, py_ff;
   logic                      oor_ff;
   logic [WTW-1:0]            tse_ff, tsw_ff, tne_ff;
   logic [WTW-1:0]            wt_ff [4];
   logic signed [WHW-1:0]     xi_ff, yi_ff;
   logic [SIZE_W-1:0]         bnd_ff [4];
   logic                      active_ff, nz_ff;
   logic signed [CW-1:0]      sr_ff, sc_ff;
   logic [ACW-1:0]            acc_r_ff, acc_g_ff, acc_b_ff;
   logic                      rsp_valid_ff;
   logic [3*PIX_W-1:0]        rsp_data_ff;
   logic                      rsp_user_ff, rsp_last_ff;

   logic [SIZE_W-1:0]         w_c, h_c;
   logic signed [17:0]        mul_a;
   logic signed [14:0]        mul_b;
   logic signed [32:0]        prod;
   logic [WTW-1:0]            prod_wt;
   logic [FRAC_W-1:0]         fx, fy;
   logic signed [CW-1:0]      wx, hx, xe, ye, ex, ey, stx, sty;
   logic signed [CW-1:0]      nr, nc;
   logic                      nb_ok;
   logic                      last_col, last_row;
   logic [WTW-1:0]            cur_wt;
   logic [ACW-1:0]            pr, pg, pb;

   // clamp frame size to the supported range
   always_comb begin
      if (fw_ff < SIZE_W'(2)) begin
         w_c = SIZE_W'(2);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         w_c = SIZE_W'(MAX_WIDTH);
      end else begin
         w_c = fw_ff;
      end
      if (fh_ff < SIZE_W'(2)) begin
         h_c = SIZE_W'(2);
      end else if (32'(fh_ff) > MAX_HEIGHT) begin
         h_c = SIZE_W'(MAX_HEIGHT);
      end else begin
         h_c = fh_ff;
      end
   end

   assign fx = px_ff[FRAC_W-1:0];
   assign fy = py_ff[FRAC_W-1:0];

   // shared multiplier of the frame latch sequence
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_PX: begin
            mul_a = -(18'(sx_ff));
            mul_b = 15'({1'b0, w_c[SIZE_W-1:1]});
         end
         OP_PY: begin
            mul_a = 18'(sy_ff);
            mul_b = 15'({1'b0, h_c[SIZE_W-1:1]});
         end
         OP_SE: begin
            mul_a = 18'({1'b0, fx});
            mul_b = 15'({1'b0, fy});
         end
         OP_SW: begin
            mul_a = 18'(ONE_Q13) - 18'({1'b0, fx});
            mul_b = 15'({1'b0, fy});
         end
         OP_NE: begin
            mul_a = 18'({1'b0, fx});
            mul_b = 15'(ONE_Q13) - 15'({1'b0, fy});
         end
         default: begin
         end
      endcase
      prod    = mul_a * mul_b;
      prod_wt = prod[WT_LSB +: WTW];
   end

   // window bounds from the whole shift of the frame being latched
   always_comb begin
      wx = CW'({1'b0, w_c});
      hx = CW'({1'b0, h_c});
      xe = CW'($signed(px_ff[PXW-1:FRAC_W]));
      ye = CW'($signed(py_ff[PXW-1:FRAC_W]));
      ex = wx - xe - CW'(1);
      ey = hx - ye - CW'(1);
      if (ex > wx) ex = wx;
      if (ey > hx) ey = hx;
      if (ex == wx) ex = wx - CW'(1);
      if (ey == hx) ey = hx - CW'(1);
      if (ex < 0) ex = '0;
      if (ey < 0) ey = '0;
      stx = -xe;
      sty = -ye;
      if (stx < 0) stx = '0;
      if (sty < 0) sty = '0;
      if (stx > wx) stx = wx;
      if (sty > hx) sty = hx;
   end

   // neighbor place and store address
   always_comb begin
      nr    = sr_ff + CW'(cmd.rd_nb[1]);
      nc    = sc_ff + CW'(cmd.rd_nb[0]);
      nb_ok = (nr >= 0) && (32'(nr) < MAX_HEIGHT) && (nc >= 0) && (32'(nc) < MAX_WIDTH);
      rd_en = (cmd.op == OP_READ);
      rd_addr = (bank_ff ? AW'(0) : AW'(BANK_SIZE)) + AW'(nr) * AW'(MAX_WIDTH) + AW'(nc);
      wr_en   = (cmd.op == OP_CHK) && (32'(i_ff) < MAX_WIDTH) && (32'(j_ff) < MAX_HEIGHT);
      wr_addr = (bank_ff ? AW'(BANK_SIZE) : AW'(0)) + AW'(j_ff) * AW'(MAX_WIDTH) + AW'(i_ff);
      wr_data = pix_ff;
   end

   // blend terms of one neighbor, red in the low byte
   always_comb begin
      cur_wt = wt_ff[cmd.acc_nb];
      if (nz_ff) begin
         pr = '0;
         pg = '0;
         pb = '0;
      end else begin
         pr = ACW'(rd_data[PIX_W-1:0]) * ACW'(cur_wt);
         pg = ACW'(rd_data[2*PIX_W-1:PIX_W]) * ACW'(cur_wt);
         pb = ACW'(rd_data[3*PIX_W-1:2*PIX_W]) * ACW'(cur_wt);
      end
   end

   assign last_col = (i_ff >= w_c - SIZE_W'(1));
   assign last_row = (j_ff >= h_c - SIZE_W'(1));

   assign sts.first_pix = (i_ff == '0) && (j_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff        <= SIZE_W'(256);
         fh_ff        <= SIZE_W'(256);
         sx_ff        <= '0;
         sy_ff        <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         bank_ff      <= 1'b0;
         have_ff      <= 1'b0;
         wt_ff[0]     <= WTW'(1 << WEIGHT_SHIFT);
         wt_ff[1]     <= '0;
         wt_ff[2]     <= '0;
         wt_ff[3]     <= '0;
         xi_ff        <= '0;
         yi_ff        <= '0;
         bnd_ff[0]    <= '0;
         bnd_ff[1]    <= '0;
         bnd_ff[2]    <= '0;
         bnd_ff[3]    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  fw_ff <= csr_data[SIZE_W-1:0];
               CSR_FRAME_HEIGHT: fh_ff <= csr_data[SIZE_W-1:0];
               CSR_SHIFT_X:      sx_ff <= csr_data;
               CSR_SHIFT_Y:      sy_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.op == OP_FIN) begin
            if (oor_ff) begin
               bnd_ff[0] <= '0;
               bnd_ff[1] <= '0;
               bnd_ff[2] <= '0;
               bnd_ff[3] <= '0;
            end else begin
               wt_ff[3]  <= tse_ff;
               wt_ff[2]  <= tsw_ff;
               wt_ff[1]  <= tne_ff;
               wt_ff[0]  <= WTW'(1 << WEIGHT_SHIFT) - (tse_ff + tsw_ff + tne_ff);
               xi_ff     <= px_ff[PXW-1:FRAC_W];
               yi_ff     <= py_ff[PXW-1:FRAC_W];
               bnd_ff[0] <= stx[SIZE_W-1:0];
               bnd_ff[1] <= sty[SIZE_W-1:0];
               bnd_ff[2] <= ex[SIZE_W-1:0];
               bnd_ff[3] <= ey[SIZE_W-1:0];
            end
         end
         if (cmd.op == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
            if (last_col) begin
               i_ff <= '0;
               if (last_row) begin
                  j_ff    <= '0;
                  bank_ff <= !bank_ff;
                  have_ff <= 1'b1;
               end else begin
                  j_ff <= j_ff + SIZE_W'(1);
               end
            end else begin
               i_ff <= i_ff + SIZE_W'(1);
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: pix_ff <= req_tdata;
         OP_PX: begin
            px_ff  <= prod[PXW-1:0];
            oor_ff <= (sx_ff > SHIFT_W'(SHIFT_LIM)) || (sx_ff < -SHIFT_W'(SHIFT_LIM))
                   || (sy_ff > SHIFT_W'(SHIFT_LIM)) || (sy_ff < -SHIFT_W'(SHIFT_LIM));
         end
         OP_PY: py_ff  <= prod[PXW-1:0];
         OP_SE: tse_ff <= prod_wt;
         OP_SW: tsw_ff <= prod_wt;
         OP_NE: tne_ff <= prod_wt;
         OP_CHK: begin
            active_ff <= have_ff && (i_ff >= bnd_ff[0]) && (i_ff < bnd_ff[2])
                      && (j_ff >= bnd_ff[1]) && (j_ff < bnd_ff[3]);
            sr_ff     <= CW'({1'b0, j_ff}) + CW'(yi_ff);
            sc_ff     <= CW'({1'b0, i_ff}) + CW'(xi_ff);
            acc_r_ff  <= '0;
            acc_g_ff  <= '0;
            acc_b_ff  <= '0;
         end
         OP_READ: nz_ff <= !(nb_ok && active_ff);
         OP_OUT: begin
            rsp_data_ff <= {acc_b_ff[WEIGHT_SHIFT +: PIX_W], acc_g_ff[WEIGHT_SHIFT +: PIX_W],
                            acc_r_ff[WEIGHT_SHIFT +: PIX_W]};
            rsp_user_ff <= have_ff;
            rsp_last_ff <= last_col && last_row;
         end
         default: begin
         end
      endcase
      if (cmd.acc_en) begin
         acc_r_ff <= acc_r_ff + pr;
         acc_g_ff <= acc_g_ff + pg;
         acc_b_ff <= acc_b_ff + pb;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/bilinear_subpixel_image_shift.sv -----
// bilinear_subpixel_image_shift: top level of the sub-pixel image shift block
// instantiates bsis_ctrl, bsis_dp and bsis_ram; uses bsis_pkg
//
// usage
//   req_* takes rgb pixels in raster order, one transfer per pixel.
//   rsp_* gives one transfer per input pixel: the previous frame's pixel at
//   that place, moved by shift_x / shift_y and blended from four neighbors.
//   rsp_tuser is low during the first frame (colors then zero), rsp_tlast
//   marks the last pixel of a frame.
//   csr_* writes frame_width, frame_height, shift_x, shift_y; it is always
//   ready. shifts are sampled at the first pixel of each frame; sizes also at each pixel.
// sequence
//   a pixel passes in order through capture, window check and store write,
//   four neighbor reads through the single read port of the frame store, a
//   final accumulate and the output load. the first pixel of a frame runs,
//   between capture and window check, the shared multiplier that works out
//   the weights, whole shift and window. one pixel is in flight at a time.
// reset
//   synchronous, active high; frame counters and bank select clear, the weights
//   put full weight on the base neighbor, the frame store is not cleared.
// stall
//   the result sits in the output register; the next pixel is accepted and
//   processed, then waits for that register to drain before it loads.
module bilinear_subpixel_image_shift #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int WEIGHT_SHIFT = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   // slave side
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [3*bsis_pkg::PIX_W-1:0]       req_tdata,   // in_red, in_green, in_blue
   // master side
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [3*bsis_pkg::PIX_W-1:0]       rsp_tdata,   // out_red, out_green, out_blue
   output logic                               rsp_tuser,   // out_valid
   output logic                               rsp_tlast,   // frame_end
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bsis_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bsis_pkg::SHIFT_W-1:0]       csr_data
);
   import bsis_pkg::*;

   // two banks of the frame store, previous and current frame
   localparam int DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   cmd_type            cmd;
   sts_type            sts;
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [3*PIX_W-1:0] wr_data, rd_data;

   assign csr_ready = 1'b1;

   bsis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bsis_dp #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .WEIGHT_SHIFT (WEIGHT_SHIFT),
      .AW           (AW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // frame store
   bsis_ram #(
      .WIDTH (3 * PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
